FILE: rtl/pitp_pkg.sv
package pitp_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int CH_W        = 8;
    localparam int VALUE_W     = 32;
    localparam int RADIX_W     = 2;
    localparam int DIGIT_W     = 4;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - RADIX_W - CH_W;

    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_SEVEN   = 8'h37;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_W-1:0] CH_X_LOWER = 8'h78;
    localparam logic [CH_W-1:0] CH_X_UPPER = 8'h58;
    localparam logic [CH_W-1:0] CH_A_LOWER = 8'h61;
    localparam logic [CH_W-1:0] CH_F_LOWER = 8'h66;
    localparam logic [CH_W-1:0] CH_A_UPPER = 8'h41;
    localparam logic [CH_W-1:0] CH_F_UPPER = 8'h46;
    localparam logic [CH_W-1:0] HEX_LETTER_OFFSET = 8'd10;

    typedef enum logic [RADIX_W-1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
        logic               ok_oct;
        logic               ok_dec;
        logic               ok_hex;
        logic [DIGIT_W-1:0] digit;
    } char_class_t;

endpackage

FILE: rtl/pitp_front.sv
module pitp_front
(
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,
    input  logic                    q_full,
    output logic                    q_push,
    output pitp_pkg::char_class_t   q_wdata
);

    logic [pitp_pkg::CH_W-1:0] ch;
    logic                      is_dec_digit;
    logic                      is_lower_hex;
    logic                      is_upper_hex;

    assign ch            = s_axis_tdata[pitp_pkg::CH_W-1:0];
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    assign is_dec_digit = (ch >= pitp_pkg::CH_ZERO) && (ch <= pitp_pkg::CH_NINE);
    assign is_lower_hex = (ch >= pitp_pkg::CH_A_LOWER) && (ch <= pitp_pkg::CH_F_LOWER);
    assign is_upper_hex = (ch >= pitp_pkg::CH_A_UPPER) && (ch <= pitp_pkg::CH_F_UPPER);

    always_comb
    begin
        q_wdata.ch       = ch;
        q_wdata.is_minus = (ch == pitp_pkg::CH_MINUS);
        q_wdata.is_zero  = (ch == pitp_pkg::CH_ZERO);
        q_wdata.is_x     = (ch == pitp_pkg::CH_X_LOWER) || (ch == pitp_pkg::CH_X_UPPER);
        q_wdata.ok_oct   = (ch >= pitp_pkg::CH_ZERO) && (ch <= pitp_pkg::CH_SEVEN);
        q_wdata.ok_dec   = is_dec_digit;
        q_wdata.ok_hex   = is_dec_digit || is_lower_hex || is_upper_hex;
        if (is_lower_hex)
        begin
            q_wdata.digit = pitp_pkg::DIGIT_W'(ch - pitp_pkg::CH_A_LOWER
                                               + pitp_pkg::HEX_LETTER_OFFSET);
        end
        else if (is_upper_hex)
        begin
            q_wdata.digit = pitp_pkg::DIGIT_W'(ch - pitp_pkg::CH_A_UPPER
                                               + pitp_pkg::HEX_LETTER_OFFSET);
        end
        else
        begin
            q_wdata.digit = pitp_pkg::DIGIT_W'(ch - pitp_pkg::CH_ZERO);
        end
    end

endmodule

FILE: rtl/pitp_queue.sv
module pitp_queue
#(
    parameter int DEPTH = pitp_pkg::QUEUE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  pitp_pkg::char_class_t   wdata,
    output logic                    full,
    input  logic                    pop,
    output logic                    rvalid,
    output pitp_pkg::char_class_t   rdata
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pitp_pkg::char_class_t mem [DEPTH];
    pitp_pkg::char_class_t head_reg;

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             head_valid_reg;
    logic             head_valid_next;
    logic             do_push;
    logic             do_pop;
    logic             load_head;
    logic             from_mem;
    logic             bypass;
    logic             mem_write;

    // The head word sits in a register; the memory holds the words behind it.
    assign full      = (count_reg == FULL_CNT);
    assign rvalid    = head_valid_reg;
    assign rdata     = head_reg;
    assign do_push   = push && !full;
    assign do_pop    = pop && head_valid_reg;
    assign load_head = !head_valid_reg || do_pop;
    assign from_mem  = load_head && (count_reg != '0);
    assign bypass    = load_head && (count_reg == '0) && do_push;
    assign mem_write = do_push && !bypass;

    always_comb
    begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        count_next      = count_reg;
        head_valid_next = head_valid_reg;
        if (mem_write)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (from_mem)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (mem_write && !from_mem)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (from_mem && !mem_write)
        begin
            count_next = count_reg - 1'b1;
        end
        if (load_head)
        begin
            head_valid_next = from_mem || bypass;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            head_valid_reg <= head_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_write)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
        if (from_mem)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
        else if (bypass)
        begin
            head_reg <= wdata;
        end
    end

endmodule

FILE: rtl/pitp_back.sv
module pitp_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  pitp_pkg::char_class_t   q_rdata,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [31:0]             out_value,
    output logic [1:0]              out_radix_code,
    output logic [7:0]              out_end_char
);

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_ZERO   = 2'd2,
        PH_DIGITS = 2'd3
    } phase_t;

    phase_t                          phase_reg;
    phase_t                          phase_next;
    logic                            negative_reg;
    logic                            negative_next;
    pitp_pkg::radix_t                radix_reg;
    pitp_pkg::radix_t                radix_next;
    logic [pitp_pkg::VALUE_W-1:0]    acc_reg;
    logic [pitp_pkg::VALUE_W-1:0]    acc_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [pitp_pkg::VALUE_W-1:0]    value_reg;
    logic [pitp_pkg::VALUE_W-1:0]    value_next;
    logic [pitp_pkg::RADIX_W-1:0]    radix_code_reg;
    logic [pitp_pkg::RADIX_W-1:0]    radix_code_next;
    logic [pitp_pkg::CH_W-1:0]       end_char_reg;
    logic [pitp_pkg::CH_W-1:0]       end_char_next;

    logic                            run_digits;
    logic                            digit_ok;
    logic [pitp_pkg::VALUE_W-1:0]    acc_scaled;

    assign q_pop          = q_valid && (!out_valid_reg || out_ready);
    assign out_valid      = out_valid_reg;
    assign out_value      = value_reg;
    assign out_radix_code = radix_code_reg;
    assign out_end_char   = end_char_reg;

    always_comb
    begin
        unique case (radix_reg)
            pitp_pkg::RADIX_OCT:
            begin
                digit_ok   = q_rdata.ok_oct;
                acc_scaled = {acc_reg[28:0], 3'b000};
            end
            pitp_pkg::RADIX_HEX:
            begin
                digit_ok   = q_rdata.ok_hex;
                acc_scaled = {acc_reg[27:0], 4'b0000};
            end
            default:
            begin
                digit_ok   = q_rdata.ok_dec;
                acc_scaled = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};
            end
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        negative_next   = negative_reg;
        radix_next      = radix_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        value_next      = value_reg;
        radix_code_next = radix_code_reg;
        end_char_next   = end_char_reg;
        run_digits      = 1'b0;

        if (q_pop)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (q_rdata.is_minus)
                    begin
                        negative_next = 1'b1;
                        phase_next    = PH_SIGN;
                    end
                    else if (q_rdata.is_zero)
                    begin
                        radix_next = pitp_pkg::RADIX_OCT;
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        run_digits = 1'b1;
                    end
                end
                PH_SIGN:
                begin
                    if (q_rdata.is_zero)
                    begin
                        radix_next = pitp_pkg::RADIX_OCT;
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        run_digits = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if (q_rdata.is_x)
                    begin
                        radix_next = pitp_pkg::RADIX_HEX;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        run_digits = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    run_digits = 1'b1;
                end
            endcase

            if (run_digits)
            begin
                phase_next = PH_DIGITS;
                if (digit_ok)
                begin
                    acc_next = acc_scaled
                               + {{(pitp_pkg::VALUE_W-pitp_pkg::DIGIT_W){1'b0}},
                                  q_rdata.digit};
                end
                else
                begin
                    out_valid_next  = 1'b1;
                    value_next      = negative_reg ? (~acc_reg + 1'b1) : acc_reg;
                    radix_code_next = radix_reg;
                    end_char_next   = q_rdata.ch;
                    phase_next      = PH_START;
                    negative_next   = 1'b0;
                    radix_next      = pitp_pkg::RADIX_DEC;
                    acc_next        = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            negative_reg   <= 1'b0;
            radix_reg      <= pitp_pkg::RADIX_DEC;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            value_reg      <= '0;
            radix_code_reg <= '0;
            end_char_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            negative_reg   <= negative_next;
            radix_reg      <= radix_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
            value_reg      <= value_next;
            radix_code_reg <= radix_code_next;
            end_char_reg   <= end_char_next;
        end
    end

endmodule

FILE: rtl/prefixed_integer_text_parser.sv
// A number's end character is registered in the queue head, then its result in the back
// end output register on m_axis; it is later only while earlier words still wait after an
// m_axis stall. Throughput: one character per cycle while m_axis does not stall; the
// accumulator update in the back end sets this. The character queue lets input continue
// for up to QUEUE_DEPTH + 1 words while a result waits. Reset is asynchronous and active
// low; it empties the queue and returns the parser to its start state, no result pending.
module prefixed_integer_text_parser
#(
    parameter int QUEUE_DEPTH = pitp_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] ch
    input  logic [7:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] value, [33:32] radix_code, [41:34] end_char, [47:42] zero
    output logic [47:0] m_axis_tdata
);

    pitp_pkg::char_class_t q_wdata;
    pitp_pkg::char_class_t q_rdata;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_valid;
    logic [31:0]           out_value;
    logic [1:0]            out_radix_code;
    logic [7:0]            out_end_char;

    pitp_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    pitp_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    pitp_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_rdata        (q_rdata),
        .q_pop          (q_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_value      (out_value),
        .out_radix_code (out_radix_code),
        .out_end_char   (out_end_char)
    );

    assign m_axis_tdata = {{pitp_pkg::OUT_PAD_W{1'b0}}, out_end_char, out_radix_code, out_value};

endmodule

FILE: rtl/pitp_checker.sv
module pitp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled output word changed or dropped.");

    a_radix_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[33:32] != 2'd3))
        else $error("Radix code out of range.");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[47:42] == '0))
        else $error("Padding bits of the output word are not zero.");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(!rst_n))
        else $error("Result appeared straight out of reset.");

    a_ready_without_result: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input blocked while no result word was waiting.");

endmodule

bind prefixed_integer_text_parser pitp_checker u_pitp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/prefixed_integer_text_parser_test.sv
module prefixed_integer_text_parser_test;
    import pitp_pkg::*;

    typedef enum logic [1:0] {
        PH_START,
        PH_SIGNED,
        PH_LEAD_ZERO,
        PH_DIGITS
    } parse_phase_t;

    typedef struct {
        logic [VALUE_W-1:0] value;
        radix_t             radix;
        logic [CH_W-1:0]    end_char;
    } parsed_number_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    parse_phase_t       phase;
    logic               negative;
    radix_t             radix;
    logic [VALUE_W-1:0] accumulator;

    parsed_number_t expected_numbers[$];
    bit             idling_on = 1'b0;
    int             error_count = 0;
    int             chars_sent = 0;
    int             stall_left = 0;

    prefixed_integer_text_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_parser();
        phase       = PH_START;
        negative    = 1'b0;
        radix       = RADIX_DEC;
        accumulator = '0;
    endfunction

    // Advances the parser by one character and returns 1 when that character ends a number.
    function automatic bit parse_char(input logic [CH_W-1:0] c, output parsed_number_t num);
        logic [DIGIT_W-1:0] digit;
        logic [VALUE_W-1:0] base;
        bit                 is_digit;
        if (phase == PH_START)
        begin
            if (c == CH_MINUS)
            begin
                negative = 1'b1;
                phase    = PH_SIGNED;
                return 1'b0;
            end
            phase = PH_SIGNED;
        end
        if (phase == PH_SIGNED)
        begin
            if (c == CH_ZERO)
            begin
                radix = RADIX_OCT;
                phase = PH_LEAD_ZERO;
                return 1'b0;
            end
            phase = PH_DIGITS;
        end
        else if (phase == PH_LEAD_ZERO)
        begin
            if (c == CH_X_LOWER || c == CH_X_UPPER)
            begin
                radix = RADIX_HEX;
                phase = PH_DIGITS;
                return 1'b0;
            end
            phase = PH_DIGITS;
        end
        is_digit = 1'b1;
        digit    = '0;
        if (c >= CH_ZERO && c <= ((radix == RADIX_OCT) ? CH_SEVEN : CH_NINE))
            digit = DIGIT_W'(c - CH_ZERO);
        else if (radix == RADIX_HEX && c >= CH_A_LOWER && c <= CH_F_LOWER)
            digit = DIGIT_W'(c - CH_A_LOWER + HEX_LETTER_OFFSET);
        else if (radix == RADIX_HEX && c >= CH_A_UPPER && c <= CH_F_UPPER)
            digit = DIGIT_W'(c - CH_A_UPPER + HEX_LETTER_OFFSET);
        else
            is_digit = 1'b0;
        case (radix)
            RADIX_OCT: base = 8;
            RADIX_HEX: base = 16;
            default:   base = 10;
        endcase
        if (is_digit)
        begin
            accumulator = accumulator * base + digit;
            return 1'b0;
        end
        num.value    = negative ? -accumulator : accumulator;
        num.radix    = radix;
        num.end_char = c;
        clear_parser();
        return 1'b1;
    endfunction

    task automatic send_char(input logic [CH_W-1:0] c);
        parsed_number_t num;
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge clk); while (!s_axis_tready);
        if (parse_char(c, num))
            expected_numbers.push_back(num);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic wait_for_numbers();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_numbers.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_number();
        int                 ndigits;
        int                 d;
        int                 kind;
        logic [CH_W-1:0]    c;
        if ($urandom_range(0, 2) == 0)
            send_char(CH_MINUS);
        kind    = $urandom_range(0, 2);
        ndigits = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
        if (kind != 0)
            send_char(CH_ZERO);
        if (kind == 2)
            send_char($urandom_range(0, 1) ? CH_X_UPPER : CH_X_LOWER);
        for (int i = 0; i < ndigits; i++)
        begin
            case (kind)
                0:       d = (i == 0) ? $urandom_range(1, 9) : $urandom_range(0, 9);
                1:       d = $urandom_range(0, 7);
                default: d = $urandom_range(0, 15);
            endcase
            if (d < 10)
                c = CH_W'(CH_ZERO + d);
            else
                c = CH_W'(($urandom_range(0, 1) ? CH_A_UPPER : CH_A_LOWER) + d - 10);
            send_char(c);
        end
        case ($urandom_range(0, 3))
            0:       send_char(8'h20);
            1:       send_char(8'h2C);
            2:       send_char(8'h0A);
            default: send_char(CH_W'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic send_random_text(input int char_target);
        while (chars_sent < char_target)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) send_char(CH_W'($urandom_range(0, 255)));
            else
                send_random_number();
        end
    endtask

    task automatic test_special_cases();
        send_text("-a");
        send_text("--");
        send_text("0xg");
        send_text("0XFa");
        send_char(8'hFF);
        send_text("078");
        send_text("9a");
        send_text("0");
        send_char(8'h00);
        wait_for_numbers();
    endtask

    task automatic test_random_text_with_idling();
        idling_on = 1'b1;
        send_random_text(450);
        wait_for_numbers();
        send_random_text(800);
    endtask

    task automatic test_random_text_back_to_back();
        idling_on = 1'b0;
        send_random_text(1000);
        wait_for_numbers();
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_check
        parsed_number_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_numbers.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual tdata %h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = expected_numbers.pop_front();
                if (m_axis_tdata[31:0] !== want.value)
                begin
                    $display("%0t: value expected %0d, actual %0d", $time,
                             $signed(want.value), $signed(m_axis_tdata[31:0]));
                    error_count++;
                end
                if (m_axis_tdata[33:32] !== want.radix)
                begin
                    $display("%0t: radix_code expected %0d, actual %0d", $time,
                             want.radix, m_axis_tdata[33:32]);
                    error_count++;
                end
                if (m_axis_tdata[41:34] !== want.end_char)
                begin
                    $display("%0t: end_char expected %h, actual %h", $time,
                             want.end_char, m_axis_tdata[41:34]);
                    error_count++;
                end
                if (m_axis_tdata[47:42] !== '0)
                begin
                    $display("%0t: padding expected 0, actual %h", $time, m_axis_tdata[47:42]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        clear_parser();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_cases();
        test_random_text_with_idling();
        test_random_text_back_to_back();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pitp_pkg.sv
rtl/pitp_front.sv
rtl/pitp_queue.sv
rtl/pitp_back.sv
rtl/prefixed_integer_text_parser.sv
rtl/pitp_checker.sv
tb/prefixed_integer_text_parser_test.sv
